>>> design/mer_pkg.sv
// Shared types, widths and codes for the midpoint ellipse rasterizer.
// Used by mer_alu, mer_emit and midpoint_ellipse_rasterizer; depends on nothing.
package mer_pkg;

	localparam int RADIUS_BITS = 10;
	localparam int COORD_BITS  = 12;
	localparam int OUT_BITS    = COORD_BITS + 1;
	localparam int SQ_BITS     = 2 * RADIUS_BITS;
	// Headroom for 2*a*a*b and the decision term.
	localparam int ACC_BITS    = 3 * RADIUS_BITS + 10;
	localparam int PX_BITS     = RADIUS_BITS + 1;
	localparam int PY_BITS     = RADIUS_BITS + 2;
	localparam int MUL_BITS    = SQ_BITS + RADIUS_BITS;

	localparam int IN_TDATA_BITS  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

	typedef logic signed [ACC_BITS-1:0]   acc_t;
	typedef logic        [SQ_BITS-1:0]    sq_t;
	typedef logic        [RADIUS_BITS-1:0] rad_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0]   pix_t;
	typedef logic        [PX_BITS-1:0]    px_t;
	typedef logic signed [PY_BITS-1:0]    py_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_HALF
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		acc_t    x;
		acc_t    y;
	} alu_req_t;

	typedef struct packed {
		logic   go;
		logic   fin;
		coord_t cx;
		coord_t cy;
		px_t    px;
		py_t    py;
	} emit_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQA,
		ST_SQB,
		ST_MUL,
		ST_D1,
		ST_D2,
		ST_R1_CMP,
		ST_R1_DY,
		ST_R1_DD,
		ST_R1_DX,
		ST_R1_DE1,
		ST_R1_DE2,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_T4,
		ST_T5,
		ST_T6,
		ST_T7,
		ST_R2_CHK,
		ST_R2_DX,
		ST_R2_DD,
		ST_R2_DY,
		ST_R2_DE1,
		ST_R2_DE2
	} state_t;

	function automatic acc_t sq_to_acc(sq_t v);
		return acc_t'({{(ACC_BITS - SQ_BITS){1'b0}}, v});
	endfunction

	function automatic acc_t sq_dbl(sq_t v);
		return acc_t'({{(ACC_BITS - SQ_BITS - 1){1'b0}}, v, 1'b0});
	endfunction

	function automatic acc_t rad_to_acc(rad_t v);
		return acc_t'({{(ACC_BITS - RADIUS_BITS){1'b0}}, v});
	endfunction

endpackage

>>> design/mer_alu.sv
// Shared arithmetic unit of the ellipse rasterizer: add, subtract, a narrow
// unsigned multiply and a halving that truncates toward zero. Uses mer_pkg.
module mer_alu (
	input  mer_pkg::alu_req_t req,
	output mer_pkg::acc_t     res
);

	logic [mer_pkg::MUL_BITS-1:0] prod;
	mer_pkg::acc_t                half_sum;

	assign prod = req.x[mer_pkg::SQ_BITS-1:0] * req.y[mer_pkg::RADIUS_BITS-1:0];

	// Adding the sign bit before the arithmetic shift rounds negatives toward zero.
	assign half_sum = req.x + $signed({{(mer_pkg::ACC_BITS - 1){1'b0}},
		req.x[mer_pkg::ACC_BITS-1]});

	always_comb begin
		unique case (req.op)
			mer_pkg::ALU_ADD:  res = req.x + req.y;
			mer_pkg::ALU_SUB:  res = req.x - req.y;
			mer_pkg::ALU_MUL:  res = $signed({{(mer_pkg::ACC_BITS - mer_pkg::MUL_BITS){1'b0}},
				prod});
			mer_pkg::ALU_HALF: res = half_sum >>> 1;
			default:           res = req.x;
		endcase
	end

endmodule

>>> design/mer_emit.sv
// Pixel emitter of the ellipse rasterizer: turns one point into four mirrored
// output beats, or one finished beat, through an output register. Uses mer_pkg.
module mer_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  mer_pkg::emit_cmd_t cmd,
	output logic               busy,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output mer_pkg::pix_t      pixel_x,
	output mer_pkg::pix_t      pixel_y,
	output logic               last,
	output logic               finished
);

	localparam int PIX_W = ((mer_pkg::COORD_BITS > mer_pkg::PY_BITS) ?
		mer_pkg::COORD_BITS : mer_pkg::PY_BITS) + 1;

	mer_pkg::emit_cmd_t job_q;
	logic               pend_q;
	logic [1:0]         idx_q;
	logic               ovalid_q;
	mer_pkg::pix_t      ox_q;
	mer_pkg::pix_t      oy_q;
	logic               olast_q;
	logic               ofin_q;

	logic               load;
	logic               beat_last;
	logic [PIX_W-1:0]   cx_w;
	logic [PIX_W-1:0]   cy_w;
	logic [PIX_W-1:0]   px_w;
	logic [PIX_W-1:0]   py_w;
	logic [PIX_W-1:0]   sx_w;
	logic [PIX_W-1:0]   sy_w;

	assign load      = pend_q && (!ovalid_q || m_axis_tready);
	assign beat_last = job_q.fin || (idx_q == 2'd3);

	assign cx_w = {{(PIX_W - mer_pkg::COORD_BITS){job_q.cx[mer_pkg::COORD_BITS-1]}}, job_q.cx};
	assign cy_w = {{(PIX_W - mer_pkg::COORD_BITS){job_q.cy[mer_pkg::COORD_BITS-1]}}, job_q.cy};
	assign px_w = {{(PIX_W - mer_pkg::PX_BITS){1'b0}}, job_q.px};
	assign py_w = {{(PIX_W - mer_pkg::PY_BITS){job_q.py[mer_pkg::PY_BITS-1]}}, job_q.py};

	// Beat order (+,+), (+,-), (-,+), (-,-): the high index bit mirrors x.
	assign sx_w = idx_q[1] ? (cx_w - px_w) : (cx_w + px_w);
	assign sy_w = idx_q[0] ? (cy_w - py_w) : (cy_w + py_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			idx_q    <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.go) begin
				pend_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (load) begin
				idx_q <= beat_last ? 2'd0 : idx_q + 2'd1;
				if (beat_last) begin
					pend_q <= 1'b0;
				end
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			job_q <= cmd;
		end
		if (load) begin
			ox_q    <= job_q.fin ? '0 : mer_pkg::pix_t'(sx_w[mer_pkg::OUT_BITS-1:0]);
			oy_q    <= job_q.fin ? '0 : mer_pkg::pix_t'(sy_w[mer_pkg::OUT_BITS-1:0]);
			olast_q <= beat_last;
			ofin_q  <= job_q.fin;
		end
	end

	assign busy          = pend_q;
	assign m_axis_tvalid = ovalid_q;
	assign pixel_x       = ox_q;
	assign pixel_y       = oy_q;
	assign last          = olast_q;
	assign finished      = ofin_q;

	a_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !pend_q)
		else $error("emitter launched while a job is still pending");

	a_fin_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && ofin_q) |-> olast_q)
		else $error("finished beat not marked last");

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> pend_q)
		else $error("beat index advanced outside a job");

endmodule

>>> design/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer top level: sequencer, state registers and ports.
// Uses mer_pkg, mer_alu and mer_emit. A start keeps the sequencer busy through SQA, SQB, MUL, D1
// and D2 (three multiplies, a subtract and an add), and no new beat is accepted until it is idle.
// A step runs its region's check and update states, or only the check past the end; the one-time
// transition adds states T1 to T7. The first beat is valid after the emitter's job and output
// registers, and the four beats leave back to back when never stalled. Ready returns once the
// sequencer is idle and all four beats are registered (the last may still wait at the output).
// Reset (arst_n low, asynchronous) leaves the finished state: a step then gives one finished beat.
module midpoint_ellipse_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: center_x[11:0], center_y[23:12], radius_x[33:24],
	// radius_y[43:34], zero fill up to 48 bits.
	input  logic [mer_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	// Field: operation (0 starts a new ellipse, 1 advances one point).
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Fields from bit 0: pixel_x[12:0], pixel_y[25:13], zero fill up to 32 bits.
	output logic [mer_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
	output logic                                m_axis_tlast,
	// Field: finished (outline complete, no pixel in this beat).
	output logic                                m_axis_tuser
);

	localparam int CX_LO = 0;
	localparam int CY_LO = CX_LO + mer_pkg::COORD_BITS;
	localparam int RX_LO = CY_LO + mer_pkg::COORD_BITS;
	localparam int RY_LO = RX_LO + mer_pkg::RADIUS_BITS;
	localparam int MSB   = mer_pkg::ACC_BITS - 1;

	// Sequencer and ellipse state.
	mer_pkg::state_t  state_q;
	mer_pkg::state_t  state_nxt;
	mer_pkg::sq_t     square_a_q;
	mer_pkg::sq_t     square_b_q;
	mer_pkg::acc_t    step_dx_q;
	mer_pkg::acc_t    step_dy_q;
	mer_pkg::acc_t    decision_q;
	mer_pkg::acc_t    tmp_q;
	mer_pkg::px_t     point_x_q;
	mer_pkg::py_t     point_y_q;
	logic             region_two_q;
	mer_pkg::coord_t  center_x_q;
	mer_pkg::coord_t  center_y_q;
	mer_pkg::rad_t    rad_a_q;
	mer_pkg::rad_t    rad_b_q;

	// Shared unit and emitter hookup.
	mer_pkg::alu_req_t  alu_req;
	mer_pkg::acc_t      alu_res;
	mer_pkg::emit_cmd_t emit_cmd;
	logic               emit_busy;
	mer_pkg::pix_t      pixel_x;
	mer_pkg::pix_t      pixel_y;

	logic             accept;
	logic             op_step;
	logic             dec_pos;
	logic             dec_neg;
	logic             y_neg;
	mer_pkg::rad_t    in_rad_b;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign op_step  = (s_axis_tuser == mer_pkg::OP_STEP);
	assign dec_neg  = decision_q[MSB];
	assign dec_pos  = !decision_q[MSB] && (decision_q != '0);
	assign y_neg    = point_y_q[mer_pkg::PY_BITS-1];
	assign in_rad_b = s_axis_tdata[RY_LO +: mer_pkg::RADIUS_BITS];

	// The sequencer only takes a beat when idle and the emitter has no job left.
	assign s_axis_tready = (state_q == mer_pkg::ST_IDLE) && !emit_busy;

	mer_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	mer_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (emit_cmd),
		.busy          (emit_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.last          (m_axis_tlast),
		.finished      (m_axis_tuser)
	);

	assign m_axis_tdata = mer_pkg::OUT_TDATA_BITS'({pixel_y, pixel_x});

	// Next state. Region one checks step_dx < step_dy through the shared unit;
	// when that fails, the transition correction runs and then region two's check.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mer_pkg::ST_IDLE: begin
				if (accept) begin
					if (!op_step) begin
						state_nxt = mer_pkg::ST_SQA;
					end else if (region_two_q) begin
						state_nxt = mer_pkg::ST_R2_CHK;
					end else begin
						state_nxt = mer_pkg::ST_R1_CMP;
					end
				end
			end
			mer_pkg::ST_SQA:    state_nxt = mer_pkg::ST_SQB;
			mer_pkg::ST_SQB:    state_nxt = mer_pkg::ST_MUL;
			mer_pkg::ST_MUL:    state_nxt = mer_pkg::ST_D1;
			mer_pkg::ST_D1:     state_nxt = mer_pkg::ST_D2;
			mer_pkg::ST_D2:     state_nxt = mer_pkg::ST_IDLE;
			mer_pkg::ST_R1_CMP: begin
				if (alu_res[MSB]) begin
					state_nxt = dec_pos ? mer_pkg::ST_R1_DY : mer_pkg::ST_R1_DX;
				end else begin
					state_nxt = mer_pkg::ST_T1;
				end
			end
			mer_pkg::ST_R1_DY:  state_nxt = mer_pkg::ST_R1_DD;
			mer_pkg::ST_R1_DD:  state_nxt = mer_pkg::ST_R1_DX;
			mer_pkg::ST_R1_DX:  state_nxt = mer_pkg::ST_R1_DE1;
			mer_pkg::ST_R1_DE1: state_nxt = mer_pkg::ST_R1_DE2;
			mer_pkg::ST_R1_DE2: state_nxt = mer_pkg::ST_IDLE;
			mer_pkg::ST_T1:     state_nxt = mer_pkg::ST_T2;
			mer_pkg::ST_T2:     state_nxt = mer_pkg::ST_T3;
			mer_pkg::ST_T3:     state_nxt = mer_pkg::ST_T4;
			mer_pkg::ST_T4:     state_nxt = mer_pkg::ST_T5;
			mer_pkg::ST_T5:     state_nxt = mer_pkg::ST_T6;
			mer_pkg::ST_T6:     state_nxt = mer_pkg::ST_T7;
			mer_pkg::ST_T7:     state_nxt = mer_pkg::ST_R2_CHK;
			mer_pkg::ST_R2_CHK: begin
				if (y_neg) begin
					state_nxt = mer_pkg::ST_IDLE;
				end else begin
					state_nxt = dec_neg ? mer_pkg::ST_R2_DX : mer_pkg::ST_R2_DY;
				end
			end
			mer_pkg::ST_R2_DX:  state_nxt = mer_pkg::ST_R2_DD;
			mer_pkg::ST_R2_DD:  state_nxt = mer_pkg::ST_R2_DY;
			mer_pkg::ST_R2_DY:  state_nxt = mer_pkg::ST_R2_DE1;
			mer_pkg::ST_R2_DE1: state_nxt = mer_pkg::ST_R2_DE2;
			mer_pkg::ST_R2_DE2: state_nxt = mer_pkg::ST_IDLE;
			default:            state_nxt = mer_pkg::ST_IDLE;
		endcase
	end

	// Operands for the shared unit, per state.
	always_comb begin
		alu_req.op   = mer_pkg::ALU_ADD;
		alu_req.x    = decision_q;
		alu_req.y    = '0;
		unique case (state_q)
			mer_pkg::ST_SQA: begin
				alu_req.op = mer_pkg::ALU_MUL;
				alu_req.x  = mer_pkg::rad_to_acc(rad_a_q);
				alu_req.y  = mer_pkg::rad_to_acc(rad_a_q);
			end
			mer_pkg::ST_SQB: begin
				alu_req.op = mer_pkg::ALU_MUL;
				alu_req.x  = mer_pkg::rad_to_acc(rad_b_q);
				alu_req.y  = mer_pkg::rad_to_acc(rad_b_q);
			end
			mer_pkg::ST_MUL: begin
				alu_req.op = mer_pkg::ALU_MUL;
				alu_req.x  = mer_pkg::sq_to_acc(square_a_q);
				alu_req.y  = mer_pkg::rad_to_acc(rad_b_q);
			end
			mer_pkg::ST_D1: begin
				// step_dy holds 2*a*a*b here; halving it is exact.
				alu_req.op = mer_pkg::ALU_SUB;
				alu_req.x  = mer_pkg::sq_to_acc(square_b_q);
				alu_req.y  = {step_dy_q[MSB], step_dy_q[MSB:1]};
			end
			mer_pkg::ST_D2: begin
				alu_req.op = mer_pkg::ALU_ADD;
				alu_req.x  = decision_q;
				alu_req.y  = mer_pkg::sq_to_acc({2'b00, square_a_q[mer_pkg::SQ_BITS-1:2]});
			end
			mer_pkg::ST_R1_CMP: begin
				alu_req.op  = mer_pkg::ALU_SUB;
				alu_req.x   = step_dx_q;
				alu_req.y   = step_dy_q;
			end
			mer_pkg::ST_R1_DY, mer_pkg::ST_R2_DY: begin
				alu_req.op = mer_pkg::ALU_SUB;
				alu_req.x  = step_dy_q;
				alu_req.y  = mer_pkg::sq_dbl(square_a_q);
			end
			mer_pkg::ST_R1_DD: begin
				alu_req.op = mer_pkg::ALU_SUB;
				alu_req.x  = decision_q;
				alu_req.y  = step_dy_q;
			end
			mer_pkg::ST_R1_DX, mer_pkg::ST_R2_DX: begin
				alu_req.op = mer_pkg::ALU_ADD;
				alu_req.x  = step_dx_q;
				alu_req.y  = mer_pkg::sq_dbl(square_b_q);
			end
			mer_pkg::ST_R1_DE1: begin
				alu_req.op = mer_pkg::ALU_ADD;
				alu_req.x  = decision_q;
				alu_req.y  = mer_pkg::sq_to_acc(square_b_q);
			end
			mer_pkg::ST_R1_DE2, mer_pkg::ST_R2_DD: begin
				alu_req.op = mer_pkg::ALU_ADD;
				alu_req.x  = decision_q;
				alu_req.y  = step_dx_q;
			end
			mer_pkg::ST_T1: begin
				alu_req.op = mer_pkg::ALU_SUB;
				alu_req.x  = mer_pkg::sq_to_acc(square_a_q);
				alu_req.y  = mer_pkg::sq_to_acc(square_b_q);
			end
			mer_pkg::ST_T2: begin
				alu_req.op = mer_pkg::ALU_ADD;
				alu_req.x  = tmp_q;
				alu_req.y  = {tmp_q[MSB-1:0], 1'b0};
			end
			mer_pkg::ST_T3, mer_pkg::ST_T6: begin
				alu_req.op = mer_pkg::ALU_HALF;
				alu_req.x  = tmp_q;
			end
			mer_pkg::ST_T4: begin
				alu_req.op = mer_pkg::ALU_SUB;
				alu_req.x  = tmp_q;
				alu_req.y  = step_dx_q;
			end
			mer_pkg::ST_T5: begin
				alu_req.op = mer_pkg::ALU_SUB;
				alu_req.x  = tmp_q;
				alu_req.y  = step_dy_q;
			end
			mer_pkg::ST_T7: begin
				alu_req.op = mer_pkg::ALU_ADD;
				alu_req.x  = decision_q;
				alu_req.y  = tmp_q;
			end
			mer_pkg::ST_R2_DE1: begin
				alu_req.op = mer_pkg::ALU_ADD;
				alu_req.x  = decision_q;
				alu_req.y  = mer_pkg::sq_to_acc(square_a_q);
			end
			mer_pkg::ST_R2_DE2: begin
				alu_req.op = mer_pkg::ALU_SUB;
				alu_req.x  = decision_q;
				alu_req.y  = step_dy_q;
			end
			default: begin
				alu_req.op = mer_pkg::ALU_ADD;
			end
		endcase
	end

	// Emitter launch. The point is handed to the emitter before it moves, so beats
	// and updates overlap.
	always_comb begin
		emit_cmd.go  = 1'b0;
		emit_cmd.fin = 1'b0;
		emit_cmd.cx  = center_x_q;
		emit_cmd.cy  = center_y_q;
		emit_cmd.px  = point_x_q;
		emit_cmd.py  = point_y_q;
		if (state_q == mer_pkg::ST_R1_CMP) begin
			emit_cmd.go = alu_res[MSB];
		end else if (state_q == mer_pkg::ST_R2_CHK) begin
			emit_cmd.go  = 1'b1;
			emit_cmd.fin = y_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Ellipse state: the reset values make the first step report finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_a_q   <= '0;
			square_b_q   <= '0;
			step_dx_q    <= '0;
			step_dy_q    <= '0;
			decision_q   <= '0;
			tmp_q        <= '0;
			point_x_q    <= '0;
			point_y_q    <= '1;
			region_two_q <= 1'b1;
			center_x_q   <= '0;
			center_y_q   <= '0;
			rad_a_q      <= '0;
			rad_b_q      <= '0;
		end else begin
			case (state_q)
				mer_pkg::ST_IDLE: begin
					if (accept && !op_step) begin
						center_x_q   <= s_axis_tdata[CX_LO +: mer_pkg::COORD_BITS];
						center_y_q   <= s_axis_tdata[CY_LO +: mer_pkg::COORD_BITS];
						rad_a_q      <= s_axis_tdata[RX_LO +: mer_pkg::RADIUS_BITS];
						rad_b_q      <= in_rad_b;
						point_x_q    <= '0;
						point_y_q    <= $signed({2'b00, in_rad_b});
						step_dx_q    <= '0;
						region_two_q <= 1'b0;
					end
				end
				mer_pkg::ST_SQA: square_a_q <= alu_res[mer_pkg::SQ_BITS-1:0];
				mer_pkg::ST_SQB: square_b_q <= alu_res[mer_pkg::SQ_BITS-1:0];
				mer_pkg::ST_MUL: step_dy_q  <= {alu_res[MSB-1:0], 1'b0};
				mer_pkg::ST_D1, mer_pkg::ST_D2, mer_pkg::ST_R1_DD, mer_pkg::ST_R1_DE1,
				mer_pkg::ST_R1_DE2, mer_pkg::ST_R2_DD, mer_pkg::ST_R2_DE1,
				mer_pkg::ST_R2_DE2: begin
					decision_q <= alu_res;
				end
				mer_pkg::ST_R1_DY, mer_pkg::ST_R2_DY: begin
					step_dy_q <= alu_res;
					point_y_q <= point_y_q - mer_pkg::PY_BITS'(1);
				end
				mer_pkg::ST_R1_DX, mer_pkg::ST_R2_DX: begin
					step_dx_q <= alu_res;
					point_x_q <= point_x_q + mer_pkg::PX_BITS'(1);
				end
				mer_pkg::ST_T1, mer_pkg::ST_T2, mer_pkg::ST_T3, mer_pkg::ST_T4,
				mer_pkg::ST_T5, mer_pkg::ST_T6: begin
					tmp_q <= alu_res;
				end
				mer_pkg::ST_T7: begin
					decision_q   <= alu_res;
					region_two_q <= 1'b1;
				end
				default: begin
					tmp_q <= tmp_q;
				end
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != mer_pkg::ST_IDLE))
		else $error("accepted beat left the sequencer idle");

	a_region_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(region_two_q) |-> ($past(state_q) == mer_pkg::ST_T7))
		else $error("region two entered without the transition correction");

	a_chk_in_region_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mer_pkg::ST_R2_CHK) |-> region_two_q)
		else $error("region two check reached while still in region one");

endmodule
